// ===== src/rwmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rwmc_pkg: shared definitions for the random walk maze carver
// Direction codes, passage bits, register indexes, field widths and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rwmc_pkg;

	// default grid limits
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	// register widths and reset values
	localparam int SIZE_REG_W   = 7;
	localparam int START_REG_W  = 6;
	localparam int CFG_INDEX_W  = 2;
	localparam logic [SIZE_REG_W-1:0]  RST_GRID_WIDTH  = 7'd64;
	localparam logic [SIZE_REG_W-1:0]  RST_GRID_HEIGHT = 7'd64;
	localparam logic [START_REG_W-1:0] RST_START_X     = 6'd0;
	localparam logic [START_REG_W-1:0] RST_START_Y     = 6'd0;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_X     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_Y     = 2'd3;

	// stream field widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;
	localparam int PORT_XY_W  = 6;
	localparam int CELLS_W    = 12;
	localparam int BITS_W     = 4;

	// direction codes
	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_S = 2'd1;
	localparam logic [1:0] DIR_W = 2'd2;
	localparam logic [1:0] DIR_E = 2'd3;

	// passage bits
	localparam logic [BITS_W-1:0] PASS_N = 4'd1;
	localparam logic [BITS_W-1:0] PASS_S = 4'd2;
	localparam logic [BITS_W-1:0] PASS_W = 4'd4;
	localparam logic [BITS_W-1:0] PASS_E = 4'd8;

	// chosen move of one step
	typedef struct packed {
		logic       found;
		logic [1:0] dir;
	} step_sel_t;

	function automatic logic [BITS_W-1:0] dir_bit(input logic [1:0] dir);
		logic [BITS_W-1:0] b;
		case (dir)
			DIR_N:   b = PASS_N;
			DIR_S:   b = PASS_S;
			DIR_W:   b = PASS_W;
			default: b = PASS_E;
		endcase
		return b;
	endfunction

	function automatic logic [1:0] opposite_dir(input logic [1:0] dir);
		logic [1:0] o;
		case (dir)
			DIR_N:   o = DIR_S;
			DIR_S:   o = DIR_N;
			DIR_W:   o = DIR_E;
			default: o = DIR_W;
		endcase
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== src/rwmc_grid_mem.sv =====
// ----------------------------------------------------------------------------
// rwmc_grid_mem: passage bit store of the grid
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rwmc_grid_mem #(
	parameter int AW    = 12,
	parameter int DEPTH = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [rwmc_pkg::BITS_W-1:0] wdata,
	input  wire logic                       re,
	input  wire logic [AW-1:0]              raddr,
	output logic      [rwmc_pkg::BITS_W-1:0] rdata
);
	import rwmc_pkg::*;

	logic [BITS_W-1:0] mem_q [DEPTH];
	logic [BITS_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/rwmc_dir_sel.sv =====
// ----------------------------------------------------------------------------
// rwmc_dir_sel: move selection of one walk step
// Picks the first of four trial directions that stays in the grid and gives
// the neighbor coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module rwmc_dir_sel #(
	parameter int XW  = 6,
	parameter int YW  = 6,
	parameter int EWW = 7,
	parameter int EHW = 7
) (
	input  wire logic [XW-1:0]    pos_x,
	input  wire logic [YW-1:0]    pos_y,
	input  wire logic [EWW-1:0]   eff_w,
	input  wire logic [EHW-1:0]   eff_h,
	input  wire logic [7:0]       try_dirs,
	output rwmc_pkg::step_sel_t   sel,
	output logic      [XW-1:0]    nbr_x,
	output logic      [YW-1:0]    nbr_y
);
	import rwmc_pkg::*;

	logic [3:0] dir_ok;
	logic [1:0] d;

	// bounds of each direction
	always_comb begin
		dir_ok[DIR_N] = (pos_y != '0);
		dir_ok[DIR_S] = ((32'(pos_y) + 1) < 32'(eff_h));
		dir_ok[DIR_W] = (pos_x != '0);
		dir_ok[DIR_E] = ((32'(pos_x) + 1) < 32'(eff_w));
	end

	// first in-bounds try wins
	always_comb begin
		sel.found = 1'b0;
		sel.dir   = DIR_N;
		for (int i = 0; i < 4; i++) begin
			d = try_dirs[2*i +: 2];
			if (!sel.found && dir_ok[d]) begin
				sel.found = 1'b1;
				sel.dir   = d;
			end
		end
	end

	// neighbor coordinates
	always_comb begin
		nbr_x = pos_x;
		nbr_y = pos_y;
		case (sel.dir)
			DIR_N:   nbr_y = YW'(pos_y - 1'b1);
			DIR_S:   nbr_y = YW'(pos_y + 1'b1);
			DIR_W:   nbr_x = XW'(pos_x - 1'b1);
			default: nbr_x = XW'(pos_x + 1'b1);
		endcase
	end

endmodule

`default_nettype wire

// ===== src/random_walk_maze_carver.sv =====
// ----------------------------------------------------------------------------
// random_walk_maze_carver: random walk (spanning tree) maze carver
// Walks a grid, opening passages into untouched cells, and reads cells back.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transfer is one item. s_tuser is the item kind
//   (0 walk one step, 1 read one cell); s_tdata carries the four trial
//   directions and the read coordinates. Output stream m_*: one result per
//   item, in order.
//   Configuration: cfg_wr_en/cfg_index/cfg_data write grid size and start
//   cell; each write restarts the carve.
//   Timing: a new item is taken only after the last one has committed. The
//   grid memory returns the neighbor cell in the cycle after the input
//   transfer; the walker cell write and the new position follow when the
//   item commits, which waits for a free output register. The neighbor write
//   goes out in the cycle after the commit, alongside the next item. The
//   result is registered at the commit.
//   Reset and every configuration write start a clearing pass over the
//   MAX_HEIGHT * 2**ceil(log2(MAX_WIDTH)) grid memory words (4096 at
//   defaults), during which s_tready is low.
//   Stall: a result waits in the output register; the next item is still
//   taken and then holds until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module random_walk_maze_carver #(
	parameter int MAX_WIDTH  = rwmc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rwmc_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// s_tdata: try_dir_first[1:0], try_dir_second[3:2], try_dir_third[5:4],
	//          try_dir_fourth[7:6], read_x[13:8], read_y[19:14], zero[23:20]
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [rwmc_pkg::IN_DATA_W-1:0]      s_tdata,
	// s_tuser: req_type[0]
	input  wire logic                                s_tuser,
	// m_tdata: walker_x[5:0], walker_y[11:6], carved[12], cells_left[24:13],
	//          done_res[25], cell_bits[29:26], zero[31:30]
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [rwmc_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire logic                                cfg_wr_en,
	input  wire logic [rwmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [rwmc_pkg::SIZE_REG_W-1:0]     cfg_data
);
	import rwmc_pkg::*;

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = MAX_HEIGHT * (1 << XW);
	localparam int EWW   = $clog2(MAX_WIDTH + 1);
	localparam int EHW   = $clog2(MAX_HEIGHT + 1);
	localparam int CNTW  = $clog2(MAX_WIDTH * MAX_HEIGHT);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0]             state_q;
	logic [SIZE_REG_W-1:0]  grid_width_q, grid_height_q;
	logic [START_REG_W-1:0] start_x_q, start_y_q;
	logic [AW-1:0]          clr_addr_q;
	logic [XW-1:0]          pos_x_q;
	logic [YW-1:0]          pos_y_q;
	logic [BITS_W-1:0]      cur_bits_q;
	logic [CNTW-1:0]        count_q;
	logic                   pend_valid_q;
	logic [AW-1:0]          pend_addr_q;
	logic [BITS_W-1:0]      pend_bits_q;
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;

	logic                   req_read_s1;
	step_sel_t              sel_s1;
	logic [XW-1:0]          nx_s1;
	logic [YW-1:0]          ny_s1;
	logic                   in_range_s1;
	logic                   fwd_hit_s1;
	logic [BITS_W-1:0]      fwd_bits_s1;

	logic [EWW-1:0]         eff_w;
	logic [EHW-1:0]         eff_h;
	logic [XW-1:0]          start_px;
	logic [YW-1:0]          start_py;
	logic [CNTW-1:0]        count_reload;

	step_sel_t              sel;
	logic [XW-1:0]          nbr_x;
	logic [YW-1:0]          nbr_y;
	logic [5:0]             rd_x, rd_y;
	logic                   rd_in_range;

	logic                   accept;
	logic                   commit;
	logic                   walk_live;
	logic                   carve;
	logic [BITS_W-1:0]      nbr_bits;
	logic [XW-1:0]          new_x;
	logic [YW-1:0]          new_y;
	logic [CNTW-1:0]        new_count;
	logic [BITS_W-1:0]      res_bits;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [BITS_W-1:0]      mem_wdata;
	logic [AW-1:0]          mem_raddr;
	logic [BITS_W-1:0]      mem_rdata;

	// effective grid size, zero acts as one, large values clip
	always_comb begin
		if (grid_width_q == '0) begin
			eff_w = EWW'(1);
		end else if (32'(grid_width_q) > MAX_WIDTH) begin
			eff_w = EWW'(MAX_WIDTH);
		end else begin
			eff_w = EWW'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			eff_h = EHW'(1);
		end else if (32'(grid_height_q) > MAX_HEIGHT) begin
			eff_h = EHW'(MAX_HEIGHT);
		end else begin
			eff_h = EHW'(grid_height_q);
		end
	end

	// start cell clipped to the grid, count of cells left to reach
	always_comb begin
		if (32'(start_x_q) < 32'(eff_w)) begin
			start_px = XW'(start_x_q);
		end else begin
			start_px = XW'(eff_w - 1'b1);
		end
		if (32'(start_y_q) < 32'(eff_h)) begin
			start_py = YW'(start_y_q);
		end else begin
			start_py = YW'(eff_h - 1'b1);
		end
		count_reload = CNTW'((EWW + EHW)'(eff_w) * (EWW + EHW)'(eff_h) - 1'b1);
	end

	// move selection from the current walker position
	rwmc_dir_sel #(
		.XW  (XW),
		.YW  (YW),
		.EWW (EWW),
		.EHW (EHW)
	) u_dir_sel (
		.pos_x    (pos_x_q),
		.pos_y    (pos_y_q),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.try_dirs (s_tdata[7:0]),
		.sel      (sel),
		.nbr_x    (nbr_x),
		.nbr_y    (nbr_y)
	);

	assign rd_x        = s_tdata[13:8];
	assign rd_y        = s_tdata[19:14];
	assign rd_in_range = (32'(rd_x) < 32'(eff_w)) && (32'(rd_y) < 32'(eff_h));

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == ST_EXEC) && (!out_valid_q || m_tready);

	// neighbor bits, with the write of the accept cycle forwarded
	assign nbr_bits  = fwd_hit_s1 ? fwd_bits_s1 : mem_rdata;
	assign walk_live = !req_read_s1 && (count_q != '0) && sel_s1.found;
	assign carve     = commit && walk_live && (nbr_bits == '0);

	// walker and count after the item
	always_comb begin
		new_x     = pos_x_q;
		new_y     = pos_y_q;
		new_count = count_q;
		res_bits  = '0;
		if (walk_live) begin
			new_x = nx_s1;
			new_y = ny_s1;
			if (nbr_bits == '0) begin
				new_count = CNTW'(count_q - 1'b1);
			end
		end
		if (req_read_s1 && in_range_s1) begin
			res_bits = nbr_bits;
		end
	end

	// write port: clearing pass, walker cell, then deferred neighbor cell
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pend_addr_q;
		mem_wdata = pend_bits_q;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (carve) begin
			mem_we    = 1'b1;
			mem_waddr = {pos_y_q, pos_x_q};
			mem_wdata = cur_bits_q | dir_bit(sel_s1.dir);
		end else if (pend_valid_q) begin
			mem_we = 1'b1;
		end
	end

	assign mem_raddr = s_tuser ? {YW'(rd_y), XW'(rd_x)} : {nbr_y, nbr_x};

	rwmc_grid_mem #(
		.AW    (AW),
		.DEPTH (DEPTH)
	) u_grid_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// capture the item at the input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			req_read_s1 <= s_tuser;
			sel_s1      <= sel;
			nx_s1       <= nbr_x;
			ny_s1       <= nbr_y;
			in_range_s1 <= rd_in_range;
			fwd_hit_s1  <= mem_we && (mem_waddr == mem_raddr);
			fwd_bits_s1 <= mem_wdata;
		end
	end

	// deferred neighbor write payload
	always_ff @(posedge clk) begin
		if (carve) begin
			pend_addr_q <= {ny_s1, nx_s1};
			pend_bits_q <= dir_bit(opposite_dir(sel_s1.dir));
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {2'b00, res_bits, (new_count == '0), CELLS_W'(new_count),
				carve, PORT_XY_W'(new_y), PORT_XY_W'(new_x)};
		end
	end

	// control: configuration, clearing pass, walk state, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			grid_width_q  <= RST_GRID_WIDTH;
			grid_height_q <= RST_GRID_HEIGHT;
			start_x_q     <= RST_START_X;
			start_y_q     <= RST_START_Y;
			clr_addr_q    <= '0;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			cur_bits_q    <= '0;
			count_q       <= '0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// drain the output register
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				// restart the carve on any register write
				case (cfg_index)
					CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
					CFG_START_X:     start_x_q     <= cfg_data[START_REG_W-1:0];
					CFG_START_Y:     start_y_q     <= cfg_data[START_REG_W-1:0];
					default:         grid_width_q  <= grid_width_q;
				endcase
				state_q      <= ST_CLEAR;
				clr_addr_q   <= '0;
				pend_valid_q <= 1'b0;
			end else begin
				pend_valid_q <= carve;
				case (state_q)
					ST_CLEAR: begin
						pos_x_q    <= start_px;
						pos_y_q    <= start_py;
						count_q    <= count_reload;
						cur_bits_q <= '0;
						clr_addr_q <= AW'(clr_addr_q + 1'b1);
						if (clr_addr_q == AW'(DEPTH - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							state_q <= ST_EXEC;
						end
					end
					ST_EXEC: begin
						if (commit) begin
							state_q <= ST_IDLE;
							pos_x_q <= new_x;
							pos_y_q <= new_y;
							count_q <= new_count;
							// track the bits of the cell the walker stands on
							if (walk_live) begin
								if (nbr_bits == '0) begin
									cur_bits_q <= dir_bit(opposite_dir(sel_s1.dir));
								end else begin
									cur_bits_q <= nbr_bits;
								end
							end
						end
					end
					default: begin
						state_q <= ST_CLEAR;
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== src/rwmc_checker.sv =====
// ----------------------------------------------------------------------------
// rwmc_checker: port-level checks of the random walk maze carver
// Watches the streams and the configuration port over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rwmc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        cfg_wr_en
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// done flag agrees with the cell count
	a_done_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25] == (m_tdata[24:13] == 12'd0)))
		else $error("done flag disagrees with cells left");

	// a carving step reports no cell bits
	a_carve_bits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> (m_tdata[29:26] == 4'd0))
		else $error("carving step reported cell bits");

	// one item at a time: no transfer right after a transfer
	a_seq_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken in back-to-back cycles");

	// a register write starts the clearing pass
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> !s_tready)
		else $error("input ready right after a register write");

endmodule

bind random_walk_maze_carver rwmc_checker u_rwmc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_wr_en (cfg_wr_en)
);

`default_nettype wire
